FILE: rtl/dqhr_pkg.sv
// Shared types and codes for the deque with half rotation.
// No dependencies; the top level and the testbench use this package.
package dqhr_pkg;

    localparam int DEF_CAPACITY = 1024;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 11;

    // operation codes; codes above OP_REM_TAIL act as a swap
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SWAPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0] removed_value;
        logic [STATUS_W-1:0]       status;
        logic [TOTAL_W-1:0]        entry_total;
    } t_out_word;

endpackage

FILE: rtl/dqhr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dqhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/deque_with_half_rotation.sv
// Deque with half rotation: top level, sequencer over three node RAMs; uses dqhr_pkg, dqhr_ram.
// Sequence: an insert, remove or swap passes through the take, link and finish states before
// its result is registered; an ignored or dropped word or a one-entry swap goes straight to finish.
// A new word is taken only once the last one has finished, since each waits on the dependent
// link-RAM read, link update and middle-pointer read; a held result stalls the finish.
// Reset (synchronous, active low) empties the deque; node RAMs are not cleared.
module deque_with_half_rotation #(
    parameter int CAPACITY = dqhr_pkg::DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dqhr_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dqhr_pkg::t_out_word o_out_word
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int VW     = dqhr_pkg::VALUE_W;
    localparam int TW     = dqhr_pkg::TOTAL_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAKE,
        S_LINK,
        S_FIN
    } t_state;

    t_state r_state;

    // list pointers and pool bookkeeping
    logic [ADDR_W-1:0] r_head;
    logic [ADDR_W-1:0] r_tail;
    logic [ADDR_W-1:0] r_mid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_fresh;
    logic [ADDR_W-1:0] r_free_head;
    logic              r_free_ne;

    // current word
    logic [dqhr_pkg::OP_W-1:0]     r_op;
    logic signed [VW-1:0]          r_value;
    logic [ADDR_W-1:0]             r_slot;
    logic                          r_from_free;
    logic [dqhr_pkg::STATUS_W-1:0] r_status;
    logic signed [VW-1:0]          r_removed;
    logic                          r_mid_next;
    logic                          r_mid_prev;

    // result register
    logic                r_out_valid;
    dqhr_pkg::t_out_word r_out_word;

    // RAM ports
    logic              val_we, val_re;
    logic [ADDR_W-1:0] val_waddr, val_raddr;
    logic [VW-1:0]     val_wdata, val_rdata;
    logic              nxt_we, nxt_re;
    logic [ADDR_W-1:0] nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
    logic              prv_we, prv_re;
    logic [ADDR_W-1:0] prv_waddr, prv_raddr, prv_wdata, prv_rdata;

    logic              mid_rd_next, mid_rd_prev;
    logic              in_ins, in_rem, is_ins, is_rem, head_side;
    logic [CNT_W-1:0]  cnt_inc, cnt_dec;
    logic [ADDR_W-1:0] take_slot, end_slot, link_t;
    logic              full, free_more;
    logic              out_free;
    logic [TW+CNT_W-1:0] total_ext;

    // decode of the incoming and the held operation
    assign in_ins = i_in_word.operation inside {dqhr_pkg::OP_INS_HEAD, dqhr_pkg::OP_INS_TAIL};
    assign in_rem = i_in_word.operation inside {dqhr_pkg::OP_REM_HEAD, dqhr_pkg::OP_REM_TAIL};
    assign is_ins = r_op inside {dqhr_pkg::OP_INS_HEAD, dqhr_pkg::OP_INS_TAIL};
    assign is_rem = r_op inside {dqhr_pkg::OP_REM_HEAD, dqhr_pkg::OP_REM_TAIL};
    assign head_side = r_op inside {dqhr_pkg::OP_INS_HEAD, dqhr_pkg::OP_REM_HEAD};

    assign cnt_inc   = r_count + 1'b1;
    assign cnt_dec   = r_count - 1'b1;
    assign full      = (r_count == CNT_W'(CAPACITY));
    // free list keeps a node after this take only if more than one was on it
    assign free_more = ({1'b0, r_fresh} > ({1'b0, r_count} + 1'b1));
    assign take_slot = r_free_ne ? r_free_head : r_fresh[ADDR_W-1:0];
    assign end_slot  = head_side ? r_head : r_tail;
    assign link_t    = head_side ? nxt_rdata : prv_rdata;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign total_ext = {{TW{1'b0}}, r_count};

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // RAM access schedule
    //   take: value write / end-node reads / swap relink, free-list read
    //   link: second link write, middle-pointer read issued
    always_comb begin
        val_we = 1'b0;  val_waddr = r_slot; val_wdata = r_value;
        val_re = 1'b0;  val_raddr = end_slot;
        nxt_we = 1'b0;  nxt_waddr = r_slot; nxt_wdata = r_head;
        nxt_re = 1'b0;  nxt_raddr = r_mid;
        prv_we = 1'b0;  prv_waddr = r_slot; prv_wdata = r_tail;
        prv_re = 1'b0;  prv_raddr = r_mid;
        mid_rd_next = 1'b0;
        mid_rd_prev = 1'b0;
        case (r_state)
            S_TAKE: begin
                if (is_ins) begin
                    val_we    = 1'b1;
                    val_waddr = take_slot;
                    if (r_count != '0) begin
                        if (head_side) begin
                            prv_we    = 1'b1;
                            prv_waddr = r_head;
                            prv_wdata = take_slot;
                        end else begin
                            nxt_we    = 1'b1;
                            nxt_waddr = r_tail;
                            nxt_wdata = take_slot;
                        end
                    end
                    if (r_free_ne) begin
                        nxt_re    = 1'b1;
                        nxt_raddr = r_free_head;
                    end
                end else if (is_rem) begin
                    val_re = 1'b1;
                    if (head_side) begin
                        nxt_re    = 1'b1;
                        nxt_raddr = end_slot;
                    end else begin
                        prv_re    = 1'b1;
                        prv_raddr = end_slot;
                    end
                end else begin
                    // swap: close the ring, read new tail-side middle and new head
                    prv_we    = 1'b1;
                    prv_waddr = r_head;
                    prv_wdata = r_tail;
                    nxt_we    = 1'b1;
                    nxt_waddr = r_tail;
                    nxt_wdata = r_head;
                    prv_re    = 1'b1;
                    prv_raddr = r_tail;
                    nxt_re    = 1'b1;
                    nxt_raddr = r_mid;
                end
            end
            S_LINK: begin
                if (is_ins && (r_count != '0)) begin
                    if (head_side) begin
                        nxt_we      = 1'b1;
                        nxt_wdata   = r_head;
                        mid_rd_prev = cnt_inc[0];
                    end else begin
                        prv_we      = 1'b1;
                        prv_wdata   = r_tail;
                        mid_rd_next = !cnt_inc[0] && (cnt_inc != CNT_W'(2));
                    end
                end else if (is_rem) begin
                    // freed node goes on the free list through its next link
                    nxt_we    = 1'b1;
                    nxt_wdata = r_free_head;
                    if (r_count != CNT_W'(1)) begin
                        if (head_side) begin
                            mid_rd_next = !cnt_dec[0] && (cnt_dec > CNT_W'(2));
                        end else begin
                            mid_rd_prev = cnt_dec[0] && (cnt_dec > CNT_W'(2));
                        end
                    end
                end
                nxt_re = nxt_re || mid_rd_next;
                prv_re = mid_rd_prev;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_mid       <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_free_head <= '0;
            r_free_ne   <= 1'b0;
            r_out_valid <= 1'b0;
            r_mid_next  <= 1'b0;
            r_mid_prev  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op       <= i_in_word.operation;
                        r_value    <= i_in_word.value;
                        r_removed  <= '0;
                        r_mid_next <= 1'b0;
                        r_mid_prev <= 1'b0;
                        if (in_ins) begin
                            r_status <= full ? dqhr_pkg::ST_FULL : dqhr_pkg::ST_INSERTED;
                            r_state  <= full ? S_FIN : S_TAKE;
                        end else if (r_count == '0) begin
                            r_status <= dqhr_pkg::ST_EMPTY;
                            r_state  <= S_FIN;
                        end else if (in_rem) begin
                            r_status <= dqhr_pkg::ST_REMOVED;
                            r_state  <= S_TAKE;
                        end else begin
                            // single entry swap changes nothing
                            r_status <= dqhr_pkg::ST_SWAPPED;
                            r_state  <= (r_count == CNT_W'(1)) ? S_FIN : S_TAKE;
                        end
                    end
                end
                S_TAKE: begin
                    if (is_ins) begin
                        r_slot      <= take_slot;
                        r_from_free <= r_free_ne;
                        if (r_free_ne) begin
                            r_free_ne <= free_more;
                        end else begin
                            r_fresh <= r_fresh + 1'b1;
                        end
                    end else if (is_rem) begin
                        r_slot <= end_slot;
                    end
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    if (is_ins) begin
                        if (r_from_free) begin
                            r_free_head <= nxt_rdata;
                        end
                        if (r_count == '0) begin
                            r_head  <= r_slot;
                            r_tail  <= r_slot;
                            r_mid   <= r_slot;
                            r_count <= CNT_W'(1);
                        end else begin
                            r_count <= cnt_inc;
                            if (head_side) begin
                                r_head <= r_slot;
                                if (cnt_inc == CNT_W'(2)) r_mid <= r_slot;
                            end else begin
                                r_tail <= r_slot;
                                if (cnt_inc == CNT_W'(2)) r_mid <= r_head;
                            end
                        end
                    end else if (is_rem) begin
                        r_removed   <= $signed(val_rdata);
                        r_free_head <= r_slot;
                        r_free_ne   <= 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            r_head  <= '0;
                            r_tail  <= '0;
                            r_mid   <= '0;
                            r_count <= '0;
                        end else begin
                            r_count <= cnt_dec;
                            if (head_side) begin
                                r_head <= link_t;
                                if (cnt_dec == CNT_W'(1)) r_mid <= r_tail;
                                else if (cnt_dec == CNT_W'(2)) r_mid <= link_t;
                            end else begin
                                r_tail <= link_t;
                                if (cnt_dec <= CNT_W'(2)) r_mid <= r_head;
                            end
                        end
                    end else begin
                        // front half moves behind the old tail
                        r_head <= nxt_rdata;
                        r_tail <= r_mid;
                        r_mid  <= r_count[0] ? prv_rdata : r_tail;
                    end
                    r_mid_next <= mid_rd_next;
                    r_mid_prev <= mid_rd_prev;
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    // read data holds while the result register is busy
                    if (r_mid_next) r_mid <= nxt_rdata;
                    if (r_mid_prev) r_mid <= prv_rdata;
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.removed_value   <= r_removed;
                        r_out_word.status          <= r_status;
                        r_out_word.entry_total     <= total_ext[TW-1:0];
                        r_mid_next                 <= 1'b0;
                        r_mid_prev                 <= 1'b0;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    dqhr_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_value_ram (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_re   (val_re),
        .i_raddr(val_raddr),
        .o_rdata(val_rdata)
    );

    dqhr_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk  (i_clk),
        .i_we   (nxt_we),
        .i_waddr(nxt_waddr),
        .i_wdata(nxt_wdata),
        .i_re   (nxt_re),
        .i_raddr(nxt_raddr),
        .o_rdata(nxt_rdata)
    );

    dqhr_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk  (i_clk),
        .i_we   (prv_we),
        .i_waddr(prv_waddr),
        .i_wdata(prv_wdata),
        .i_re   (prv_re),
        .i_raddr(prv_raddr),
        .o_rdata(prv_rdata)
    );

    // pool accounting: fresh slots in use = entries + free-list length
    a_free_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && r_free_ne |-> (r_fresh > r_count))
        else $error("free list flagged nonempty with no spare slot");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !r_free_ne |-> (r_fresh == r_count))
        else $error("free list empty but fresh counter ahead of count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_zero_unless_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.status != dqhr_pkg::ST_REMOVED)
        |-> (r_out_word.removed_value == '0))
        else $error("nonzero removed value on a non-removal result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again without a busy cycle");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for deque_with_half_rotation: directed and random operation words,
// checked result by result against an in-bench linked-list deque with a tracked middle.
// Depends on dqhr_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int CAP     = dqhr_pkg::DEF_CAPACITY;
    localparam int SLOT_W  = $clog2(CAP);
    localparam int OP_W    = dqhr_pkg::OP_W;
    localparam int VALUE_W = dqhr_pkg::VALUE_W;
    localparam int TOTAL_W = dqhr_pkg::TOTAL_W;
    // depth reached by the fill-and-drain test
    localparam int FILL_DEPTH = 300;
    // highest code on the op field; everything above OP_SWAP aliases a swap
    localparam logic [OP_W-1:0] OP_TOP = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    dqhr_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_stall;
    dqhr_pkg::t_out_word o_out_word;

    deque_with_half_rotation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // ------------------------------------------------------------------
    // Shadow deque: node pool, links, ends, middle and slot allocator.
    // Never-written entries are never read, so their start value is moot.
    // ------------------------------------------------------------------
    bit [VALUE_W-1:0] node_val  [CAP];
    bit [SLOT_W-1:0]  link_next [CAP];
    bit [SLOT_W-1:0]  link_prev [CAP];
    bit [SLOT_W-1:0]  head_at, tail_at, mid_at;
    int               held;       // entries in the deque
    int               fresh_at;   // next never-used slot
    bit [SLOT_W-1:0]  free_top;   // head of the free list
    bit               free_any;
    int               deepest;

    dqhr_pkg::t_out_word pending_results[$];

    // bench knobs shared by the sender, receiver and tests
    bit quiet;        // no idle cycles on either side
    int hold_cycles;  // one-shot long receiver stall, picked up on its next draw

    // tallies for the closing summary
    int mismatches;
    int words_sent;
    int results_seen;
    int n_inserted, n_removed, n_swapped, n_empty, n_full;

    // Freed slot goes on top of the free list, linked through next.
    function automatic void free_slot(input bit [SLOT_W-1:0] s);
        link_next[s] = free_top;
        free_top     = s;
        free_any     = 1'b1;
    endfunction

    // Apply one word to the shadow deque and return the result it must produce.
    function automatic dqhr_pkg::t_out_word apply_deque_op(input logic [OP_W-1:0] op,
                                                           input logic signed [VALUE_W-1:0] val);
        dqhr_pkg::t_out_word r;
        bit [SLOT_W-1:0]     s, t, new_mid;
        r = '0;
        if (op inside {dqhr_pkg::OP_INS_HEAD, dqhr_pkg::OP_INS_TAIL}) begin
            if (held >= CAP) begin
                r.status = dqhr_pkg::ST_FULL;
            end else begin
                // reuse a freed slot first, else take a fresh one
                if (free_any) begin
                    s        = free_top;
                    free_top = link_next[s];
                    free_any = fresh_at > held + 1;
                end else begin
                    s = fresh_at[SLOT_W-1:0];
                    fresh_at++;
                end
                node_val[s] = val;
                r.status    = dqhr_pkg::ST_INSERTED;
                if (held == 0) begin
                    head_at = s;
                    tail_at = s;
                    mid_at  = s;
                    held    = 1;
                end else if (op == dqhr_pkg::OP_INS_HEAD) begin
                    link_prev[head_at] = s;
                    link_next[s]       = head_at;
                    head_at            = s;
                    held++;
                    if (held == 2) mid_at = head_at;
                    else if (held % 2 == 1) mid_at = link_prev[mid_at];
                end else begin
                    link_next[tail_at] = s;
                    link_prev[s]       = tail_at;
                    tail_at            = s;
                    held++;
                    if (held == 2) mid_at = head_at;
                    else if (held % 2 == 0) mid_at = link_next[mid_at];
                end
            end
        end else if (held == 0) begin
            r.status = dqhr_pkg::ST_EMPTY;
        end else if (op inside {dqhr_pkg::OP_REM_HEAD, dqhr_pkg::OP_REM_TAIL}) begin
            s               = (op == dqhr_pkg::OP_REM_HEAD) ? head_at : tail_at;
            r.removed_value = node_val[s];
            r.status        = dqhr_pkg::ST_REMOVED;
            if (held == 1) begin
                free_slot(s);
                head_at = '0;
                tail_at = '0;
                mid_at  = '0;
                held    = 0;
            end else if (op == dqhr_pkg::OP_REM_HEAD) begin
                t = link_next[s];
                free_slot(s);
                head_at = t;
                held--;
                if (held == 1) mid_at = tail_at;
                else if (held == 2) mid_at = head_at;
                else if (held % 2 == 0) mid_at = link_next[mid_at];
            end else begin
                t = link_prev[s];
                free_slot(s);
                tail_at = t;
                held--;
                if (held <= 2) mid_at = head_at;
                else if (held % 2 == 1) mid_at = link_prev[mid_at];
            end
        end else begin
            // swap halves: close the ring, cut after the middle
            r.status = dqhr_pkg::ST_SWAPPED;
            if (held >= 2) begin
                new_mid            = (held % 2 == 1) ? link_prev[tail_at] : tail_at;
                link_prev[head_at] = tail_at;
                link_next[tail_at] = head_at;
                head_at            = link_next[mid_at];
                tail_at            = mid_at;
                mid_at             = new_mid;
            end
        end
        if (held > deepest) deepest = held;
        r.entry_total = held[TOTAL_W-1:0];
        return r;
    endfunction

    // Mostly random values, with the signed extremes, zero and minus one mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(VALUE_W-1){1'b0}}};
            1: return {1'b0, {(VALUE_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, called and returning at a falling edge. Valid stays high
    // across back-to-back words; the prediction is taken at the accepting edge.
    task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          = 1'b1;
        i_in_word.operation = op;
        i_in_word.value     = val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_results.push_back(apply_deque_op(op, val));
        words_sent++;
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock, limit and receiver
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop, many times the slowest legal run
    initial begin
        #3_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("deque_with_half_rotation test failed");
        $finish;
    end

    // Receiver: per word, stall a drawn number of cycles, then take the next word.
    initial begin
        int gap;
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 6);
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                i_out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // Result checker: each accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        dqhr_pkg::t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word: removed %0d status %0d total %0d",
                         $time, o_out_word.removed_value, o_out_word.status,
                         o_out_word.entry_total);
            end else begin
                want = pending_results.pop_front();
                case (want.status)
                    dqhr_pkg::ST_INSERTED: n_inserted++;
                    dqhr_pkg::ST_REMOVED:  n_removed++;
                    dqhr_pkg::ST_SWAPPED:  n_swapped++;
                    dqhr_pkg::ST_EMPTY:    n_empty++;
                    default:               n_full++;
                endcase
                if (o_out_word.removed_value !== want.removed_value) begin
                    mismatches++;
                    $display("%0t: removed_value expected %0d actual %0d", $time,
                             want.removed_value, o_out_word.removed_value);
                end
                if (o_out_word.status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_word.status);
                end
                if (o_out_word.entry_total !== want.entry_total) begin
                    mismatches++;
                    $display("%0t: entry_total expected %0d actual %0d", $time,
                             want.entry_total, o_out_word.entry_total);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Removes, swap and the spare swap codes on an empty deque are all ignored.
    task automatic test_empty_deque();
        send_word(dqhr_pkg::OP_REM_HEAD, pick_value());
        send_word(dqhr_pkg::OP_REM_TAIL, pick_value());
        send_word(dqhr_pkg::OP_SWAP, pick_value());
        send_word(dqhr_pkg::OP_SWAP + 3'd1, pick_value());
        send_word(OP_TOP, pick_value());
    endtask

    // Short sequences: single-entry swap, last entry leaving, swaps at 2, 3
    // and 4 entries, extreme values at both ends.
    task automatic test_small_deque();
        send_word(dqhr_pkg::OP_INS_TAIL, {1'b0, {(VALUE_W-1){1'b1}}});
        send_word(dqhr_pkg::OP_SWAP, '0);
        send_word(dqhr_pkg::OP_REM_HEAD, '0);
        send_word(dqhr_pkg::OP_INS_HEAD, {1'b1, {(VALUE_W-1){1'b0}}});
        send_word(dqhr_pkg::OP_INS_TAIL, '0);
        send_word(dqhr_pkg::OP_SWAP, '1);
        send_word(dqhr_pkg::OP_INS_HEAD, '1);
        send_word(dqhr_pkg::OP_SWAP, '0);
        send_word(dqhr_pkg::OP_INS_TAIL, 32'sd12345);
        send_word(dqhr_pkg::OP_SWAP, '0);
        send_word(OP_TOP, '0);
        send_word(dqhr_pkg::OP_REM_TAIL, '1);
        send_word(dqhr_pkg::OP_REM_HEAD, '0);
        send_word(dqhr_pkg::OP_SWAP, '0);
        send_word(dqhr_pkg::OP_REM_TAIL, '0);
        send_word(dqhr_pkg::OP_REM_TAIL, '0);
        send_word(dqhr_pkg::OP_REM_HEAD, '0);
    endtask

    // Grow to a deep list with swaps sprinkled in, then drain it past empty.
    task automatic test_fill_and_drain();
        int k;
        for (k = 0; k < FILL_DEPTH; k++) begin
            send_word($urandom_range(0, 1) ? dqhr_pkg::OP_INS_TAIL : dqhr_pkg::OP_INS_HEAD,
                      pick_value());
            if (k % 37 == 5) send_word(dqhr_pkg::OP_SWAP, pick_value());
        end
        send_word(dqhr_pkg::OP_SWAP, pick_value());
        for (k = 0; k < FILL_DEPTH; k++) begin
            send_word($urandom_range(0, 1) ? dqhr_pkg::OP_REM_TAIL : dqhr_pkg::OP_REM_HEAD,
                      pick_value());
            if (k % 41 == 7) send_word(dqhr_pkg::OP_SWAP, pick_value());
        end
        send_word(dqhr_pkg::OP_REM_HEAD, pick_value());
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // block backs up and stalls its input.
    task automatic test_output_hold();
        int k;
        quiet       = 1'b1;
        hold_cycles = 200;
        for (k = 0; k < 24; k++)
            send_word((k % 3 == 2) ? dqhr_pkg::OP_REM_HEAD : dqhr_pkg::OP_INS_TAIL,
                      pick_value());
        quiet = 1'b0;
    endtask

    // Random mix in segments, each with its own growth bias, some without idling.
    task automatic test_random_mix();
        int              seg, k, grow_pct, roll;
        logic [OP_W-1:0] op;
        for (seg = 0; seg < 4; seg++) begin
            grow_pct = $urandom_range(25, 75);
            quiet    = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 50; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5)
                    op = dqhr_pkg::OP_SWAP
                         + OP_W'($urandom_range(1, OP_TOP - dqhr_pkg::OP_SWAP));
                else if (roll < 18)
                    op = dqhr_pkg::OP_SWAP;
                else if ($urandom_range(0, 99) < grow_pct)
                    op = $urandom_range(0, 1) ? dqhr_pkg::OP_INS_TAIL : dqhr_pkg::OP_INS_HEAD;
                else
                    op = $urandom_range(0, 1) ? dqhr_pkg::OP_REM_TAIL : dqhr_pkg::OP_REM_HEAD;
                send_word(op, pick_value());
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        quiet       = 1'b0;
        hold_cycles = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_deque();
        test_small_deque();
        test_fill_and_drain();
        test_output_hold();
        test_random_mix();

        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // room for any stray word past the last expected one
        repeat (20) @(posedge i_clk);

        $display("Sent %0d words, checked %0d results; deepest fill %0d of %0d.",
                 words_sent, results_seen, deepest, CAP);
        $display("Outcomes: %0d inserted, %0d removed, %0d swapped, %0d empty, %0d full.",
                 n_inserted, n_removed, n_swapped, n_empty, n_full);
        if (mismatches == 0) begin
            $display("deque_with_half_rotation test passed");
        end else begin
            $display("deque_with_half_rotation test failed");
        end
        $finish;
    end

endmodule
